// ===== hw/rtl/cht_pkg.sv =====
// Shared types, codes and sizes for the capability handle table.
`default_nettype none
package cht_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int HANDLE_W = 10;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int ITEM_W   = CMD_W + HANDLE_W + 2 * DATA_W;
    localparam int TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int TDATA_PAD = TDATA_W - ITEM_W;

    // Reset value of the duplicate-permission mask
    localparam logic [DATA_W-1:0] DUP_MASK_RESET = 32'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 3'd0,
        CMD_GET     = 3'd1,
        CMD_TAKE    = 3'd2,
        CMD_RESTORE = 3'd3,
        CMD_CLOSE   = 3'd4,
        CMD_DUP     = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_BADHANDLE = 3'd2,
        ST_DENIED    = 3'd3,
        ST_BUSY      = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_CHECK = 2'd1,
        SEQ_DUP   = 2'd2
    } seq_state_t;

    // Used-bit update from the sequencer
    typedef struct packed {
        logic             set_en;
        logic             clr_en;
        logic [IDX_W-1:0] idx;
    } slot_upd_t;

    // Lowest free slot
    typedef struct packed {
        logic             any_free;
        logic [IDX_W-1:0] idx;
    } free_info_t;

    // Rights unit result
    typedef struct packed {
        logic [DATA_W-1:0] masked;
        logic              covers;
        logic              nonzero;
    } rights_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cht_slot_map.sv =====
// Slot occupancy bits with a registered lowest-free-slot encoder.
`default_nettype none
module cht_slot_map
    import cht_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire slot_upd_t  upd,
    input  wire logic [IDX_W-1:0] lookup_idx,
    output logic            used_at,
    output free_info_t      free_info
);

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] used_next;
    free_info_t               free_reg;
    free_info_t               free_next;

    // Set or clear one used bit per request
    always_comb begin
        used_next = used_reg;
        if (upd.set_en) begin
            used_next[upd.idx] = 1'b1;
        end else if (upd.clr_en) begin
            used_next[upd.idx] = 1'b0;
        end
    end

    // Priority encode the lowest clear bit; lowest index wins
    always_comb begin
        free_next = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_next.any_free = 1'b1;
                free_next.idx      = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            free_reg <= '0;
        end else begin
            used_reg <= used_next;
            free_reg <= free_next;
        end
    end

    assign used_at   = used_reg[lookup_idx];
    assign free_info = free_reg;

`ifndef SYNTH
    // Never set and clear in the same cycle
    a_upd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(upd.set_en && upd.clr_en))
        else $error("slot set and clear together");

    // A slot is only filled while free
    a_set_free: assert property (@(posedge aclk) disable iff (!aresetn)
        upd.set_en |-> !used_reg[upd.idx])
        else $error("filling an occupied slot");

    // A slot is only freed while used
    a_clr_used: assert property (@(posedge aclk) disable iff (!aresetn)
        upd.clr_en |-> used_reg[upd.idx])
        else $error("freeing an empty slot");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/cht_rights_unit.sv =====
// Shared rights unit: AND of a slot's rights with an operand, plus cover and nonzero tests.
`default_nettype none
module cht_rights_unit
    import cht_pkg::*;
(
    input  wire logic [DATA_W-1:0] rights,
    input  wire logic [DATA_W-1:0] operand,
    output rights_res_t            res
);

    logic [DATA_W-1:0] masked;

    // One AND feeds both compares
    assign masked      = rights & operand;
    assign res.masked  = masked;
    assign res.covers  = (masked == operand);
    assign res.nonzero = (masked != '0);

endmodule
`default_nettype wire

// ===== hw/rtl/capability_handle_table_unit.sv =====
// Capability handle table: sequencer, request/result registers and config register.
// Flow: a request is accepted only in SEQ_IDLE, so no new one is taken until the last
//   completes; it takes one registered slot read, then a check-and-write-back pass of the
//   shared rights unit (a duplicate also takes a SEQ_DUP pass), held while the output stalls.
// Reset: synchronous active-low aresetn empties every slot at once (used bits),
//   sets dup_right_mask to 1 and drops any pending result.
`default_nettype none
module capability_handle_table_unit
    import cht_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Config register dup_right_mask
    input  wire logic               cfg_we,
    input  wire logic [DATA_W-1:0]  cfg_wdata,
    // Request channel
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // command[2:0], handle_index[12:3], object_id[44:13], rights_value[76:45]
    input  wire logic [TDATA_W-1:0] s_tdata,
    // Result channel
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // status[2:0], handle_out[12:3], object_out[44:13], rights_out[76:45]
    output logic [TDATA_W-1:0]      m_tdata
);

    // State and registers
    seq_state_t          seq_state_reg, seq_state_next;
    logic [DATA_W-1:0]   dup_mask_reg;
    cmd_t                req_cmd_reg;
    logic [HANDLE_W-1:0] req_idx_reg;
    logic [DATA_W-1:0]   req_obj_reg;
    logic [DATA_W-1:0]   req_rv_reg;
    logic [DATA_W-1:0]   nr_reg, nr_next;
    logic                nr_nz_reg, nr_nz_next;
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    logic                s_acc;
    logic                out_free;
    logic                in_range;
    logic                used_raw;
    logic                used_at;
    free_info_t          free_info;
    slot_upd_t           upd;
    rights_res_t         alu_res;
    logic [DATA_W-1:0]   alu_b;
    logic [IDX_W-1:0]    rd_addr;
    logic [2*DATA_W-1:0] rd_data;
    logic [DATA_W-1:0]   rd_obj, rd_rights;

    // Sequencer outputs
    logic                is_final, fin, to_dup;
    logic                wr_req, set_req, clr_req;
    logic [IDX_W-1:0]    wr_addr;
    logic [2*DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]    upd_idx;
    status_t             res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic [DATA_W-1:0]   res_obj, res_rights;

    assign s_tready = (seq_state_reg == SEQ_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range = {{(32-HANDLE_W){1'b0}}, req_idx_reg} < 32'(TABLE_ENTRIES);
    assign used_at  = in_range && used_raw;

    // Slot read address: request field at accept, held request afterwards
    assign rd_addr   = (seq_state_reg == SEQ_IDLE) ? s_tdata[CMD_W +: IDX_W]
                                                   : req_idx_reg[IDX_W-1:0];
    assign rd_obj    = rd_data[DATA_W-1:0];
    assign rd_rights = rd_data[2*DATA_W-1:DATA_W];

    cht_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (wr_req && fin),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign upd.set_en = set_req && fin;
    assign upd.clr_en = clr_req && fin;
    assign upd.idx    = upd_idx;

    cht_slot_map u_slot_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd        (upd),
        .lookup_idx (req_idx_reg[IDX_W-1:0]),
        .used_at    (used_raw),
        .free_info  (free_info)
    );

    cht_rights_unit u_rights (
        .rights  (rd_rights),
        .operand (alu_b),
        .res     (alu_res)
    );

    // Next state
    always_comb begin
        seq_state_next = seq_state_reg;
        case (seq_state_reg)
            SEQ_IDLE: begin
                if (s_acc) seq_state_next = SEQ_CHECK;
            end
            SEQ_CHECK: begin
                if (fin) seq_state_next = SEQ_IDLE;
                else if (to_dup) seq_state_next = SEQ_DUP;
            end
            SEQ_DUP: begin
                if (fin) seq_state_next = SEQ_IDLE;
            end
            default: seq_state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: checks, table write-back and result
    always_comb begin
        is_final   = 1'b0;
        to_dup     = 1'b0;
        wr_req     = 1'b0;
        set_req    = 1'b0;
        clr_req    = 1'b0;
        wr_addr    = free_info.idx;
        wr_data    = {req_rv_reg, req_obj_reg};
        upd_idx    = req_idx_reg[IDX_W-1:0];
        alu_b      = req_rv_reg;
        nr_next    = nr_reg;
        nr_nz_next = nr_nz_reg;
        res_status = ST_OK;
        res_handle = '0;
        res_obj    = '0;
        res_rights = '0;
        case (seq_state_reg)
            SEQ_CHECK: begin
                case (req_cmd_reg)
                    CMD_ALLOC: begin
                        is_final = 1'b1;
                        if (req_obj_reg == '0 || req_rv_reg == '0) begin
                            res_status = ST_INVALID;
                        end else if (!free_info.any_free) begin
                            res_status = ST_FULL;
                        end else begin
                            wr_req     = 1'b1;
                            set_req    = 1'b1;
                            upd_idx    = free_info.idx;
                            res_handle = HANDLE_W'(free_info.idx);
                        end
                    end
                    CMD_GET, CMD_TAKE: begin
                        is_final = 1'b1;
                        if (!used_at) begin
                            res_status = ST_BADHANDLE;
                        end else if (!alu_res.covers) begin
                            res_status = ST_DENIED;
                        end else begin
                            res_obj    = rd_obj;
                            res_rights = rd_rights;
                            clr_req    = (req_cmd_reg == CMD_TAKE);
                        end
                    end
                    CMD_RESTORE: begin
                        is_final = 1'b1;
                        wr_addr  = req_idx_reg[IDX_W-1:0];
                        if (req_obj_reg == '0 || req_rv_reg == '0) begin
                            res_status = ST_INVALID;
                        end else if (!in_range) begin
                            res_status = ST_BADHANDLE;
                        end else if (used_raw) begin
                            res_status = ST_BUSY;
                        end else begin
                            wr_req  = 1'b1;
                            set_req = 1'b1;
                        end
                    end
                    CMD_CLOSE: begin
                        is_final = 1'b1;
                        if (!used_at) begin
                            res_status = ST_BADHANDLE;
                        end else begin
                            clr_req = 1'b1;
                        end
                    end
                    CMD_DUP: begin
                        // First pass: masked rights, a zero mask keeps all
                        alu_b      = (req_rv_reg != '0) ? req_rv_reg : '1;
                        nr_next    = alu_res.masked;
                        nr_nz_next = alu_res.nonzero;
                        if (!used_at) begin
                            is_final   = 1'b1;
                            res_status = ST_BADHANDLE;
                        end else begin
                            to_dup = 1'b1;
                        end
                    end
                    default: begin
                        is_final   = 1'b1;
                        res_status = ST_INVALID;
                    end
                endcase
            end
            SEQ_DUP: begin
                // Second pass: duplicate permission
                is_final = 1'b1;
                alu_b    = dup_mask_reg;
                wr_data  = {nr_reg, rd_obj};
                if (!alu_res.nonzero || !nr_nz_reg) begin
                    res_status = ST_DENIED;
                end else if (!free_info.any_free) begin
                    res_status = ST_FULL;
                end else begin
                    wr_req     = 1'b1;
                    set_req    = 1'b1;
                    upd_idx    = free_info.idx;
                    res_handle = HANDLE_W'(free_info.idx);
                end
            end
            default: begin
                is_final = 1'b0;
            end
        endcase
    end

    assign fin = is_final && out_free;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_state_reg <= SEQ_IDLE;
            dup_mask_reg  <= DUP_MASK_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            seq_state_reg <= seq_state_next;
            if (cfg_we) dup_mask_reg <= cfg_wdata;
            if (fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_cmd_reg <= cmd_t'(s_tdata[CMD_W-1:0]);
            req_idx_reg <= s_tdata[CMD_W +: HANDLE_W];
            req_obj_reg <= s_tdata[CMD_W+HANDLE_W +: DATA_W];
            req_rv_reg  <= s_tdata[CMD_W+HANDLE_W+DATA_W +: DATA_W];
        end
        nr_reg    <= nr_next;
        nr_nz_reg <= nr_nz_next;
        if (fin) begin
            m_tdata_reg <= {{TDATA_PAD{1'b0}}, res_rights, res_obj, res_handle,
                            res_status};
        end
    end

`ifndef SYNTH
    // An accepted request is checked in the next cycle
    a_acc_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (seq_state_reg == SEQ_CHECK))
        else $error("accepted request not checked");

    // The duplicate pass only follows a check or itself
    a_dup_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_state_reg == SEQ_DUP) |->
            ($past(seq_state_reg) == SEQ_CHECK || $past(seq_state_reg) == SEQ_DUP))
        else $error("duplicate pass entered out of order");

    // Table writes never happen while idle
    a_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_req && fin) |-> (seq_state_reg != SEQ_IDLE))
        else $error("table write while idle");

    // A result is produced exactly when a request completes
    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |=> (m_tvalid_reg && seq_state_reg == SEQ_IDLE))
        else $error("completed request without result");
`endif

endmodule
`default_nettype wire

// ===== tb/capability_handle_table_checker.sv =====
// Request/result checker for the capability handle table: predicts every result and compares.
module capability_handle_table_checker
    import cht_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [DATA_W-1:0]  cfg_wdata,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    output int                      mismatches,
    output int                      outstanding
);

    // Bit offsets shared by request and result packing
    localparam int OFS_HANDLE = CMD_W;
    localparam int OFS_OBJ    = CMD_W + HANDLE_W;
    localparam int OFS_RIGHTS = CMD_W + HANDLE_W + DATA_W;

    typedef struct {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   obj_id;
        logic [DATA_W-1:0]   rts;
    } table_result_t;

    // Shadow copy of the table and the duplicate-permission mask
    logic [DATA_W-1:0] slot_obj  [TABLE_ENTRIES];
    logic [DATA_W-1:0] slot_rts  [TABLE_ENTRIES];
    logic              slot_live [TABLE_ENTRIES];
    logic [DATA_W-1:0] dup_mask;

    table_result_t expected_results[$];
    int            err_cnt = 0;

    function automatic int first_free_slot();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!slot_live[i]) return i;
        end
        return -1;
    endfunction

    function automatic void empty_slot(int i);
        slot_live[i] = 1'b0;
        slot_obj[i]  = '0;
        slot_rts[i]  = '0;
    endfunction

    function automatic void fill_slot(int i, logic [DATA_W-1:0] obj, logic [DATA_W-1:0] rts);
        slot_live[i] = 1'b1;
        slot_obj[i]  = obj;
        slot_rts[i]  = rts;
    endfunction

    // Apply one request to the shadow table and return the result it should give
    function automatic table_result_t apply_table_cmd(logic [CMD_W-1:0]    cmd,
                                                      logic [HANDLE_W-1:0] idx,
                                                      logic [DATA_W-1:0]   obj,
                                                      logic [DATA_W-1:0]   rv);
        table_result_t    r;
        logic             in_range;
        logic [IDX_W-1:0] s;
        logic [DATA_W-1:0] granted;
        int               f;
        r.status = ST_OK;
        r.handle = '0;
        r.obj_id = '0;
        r.rts    = '0;
        in_range = idx < TABLE_ENTRIES;
        s        = idx[IDX_W-1:0];
        f        = first_free_slot();
        case (cmd)
            CMD_ALLOC: begin
                if (obj == '0 || rv == '0) r.status = ST_INVALID;
                else if (f < 0) r.status = ST_FULL;
                else begin
                    fill_slot(f, obj, rv);
                    r.handle = HANDLE_W'(f);
                end
            end
            CMD_GET, CMD_TAKE: begin
                if (!in_range || !slot_live[s]) r.status = ST_BADHANDLE;
                else if ((slot_rts[s] & rv) != rv) r.status = ST_DENIED;
                else begin
                    r.obj_id = slot_obj[s];
                    r.rts    = slot_rts[s];
                    if (cmd == CMD_TAKE) empty_slot(s);
                end
            end
            CMD_RESTORE: begin
                // zero object or rights beats every other check
                if (obj == '0 || rv == '0) r.status = ST_INVALID;
                else if (!in_range) r.status = ST_BADHANDLE;
                else if (slot_live[s]) r.status = ST_BUSY;
                else fill_slot(s, obj, rv);
            end
            CMD_CLOSE: begin
                if (!in_range || !slot_live[s]) r.status = ST_BADHANDLE;
                else empty_slot(s);
            end
            CMD_DUP: begin
                if (!in_range || !slot_live[s]) r.status = ST_BADHANDLE;
                else if ((slot_rts[s] & dup_mask) == '0) r.status = ST_DENIED;
                else begin
                    // zero mask keeps every right
                    granted = (rv != '0) ? (slot_rts[s] & rv) : slot_rts[s];
                    if (granted == '0) r.status = ST_DENIED;
                    else if (f < 0) r.status = ST_FULL;
                    else begin
                        fill_slot(f, slot_obj[s], granted);
                        r.handle = HANDLE_W'(f);
                    end
                end
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // Track config writes, consume results, then queue the prediction for a new request
    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) empty_slot(i);
            dup_mask = DUP_MASK_RESET;
            expected_results.delete();
        end else begin
            if (cfg_we) dup_mask = cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
                    err_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_tdata[STATUS_W-1:0]);
                    check_field("handle_out", want.handle, m_tdata[OFS_HANDLE +: HANDLE_W]);
                    check_field("object_out", want.obj_id, m_tdata[OFS_OBJ +: DATA_W]);
                    check_field("rights_out", want.rts, m_tdata[OFS_RIGHTS +: DATA_W]);
                    check_field("pad", '0, m_tdata[TDATA_W-1:ITEM_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_table_cmd(s_tdata[CMD_W-1:0],
                                                           s_tdata[OFS_HANDLE +: HANDLE_W],
                                                           s_tdata[OFS_OBJ +: DATA_W],
                                                           s_tdata[OFS_RIGHTS +: DATA_W]));
            end
        end
        mismatches  <= err_cnt;
        outstanding <= expected_results.size();
    end

endmodule

// ===== tb/tb_capability_handle_table_unit.sv =====
// Testbench top for the capability handle table: stimulus, idling, watchdog and verdict.
module tb_capability_handle_table_unit;
    import cht_pkg::*;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    localparam int                STALL_LIMIT     = 2000;
    localparam int                PHASES          = 8;
    localparam int                ITEMS_PER_PHASE = 212;
    localparam int                CALM_PHASE      = 3;
    localparam logic [DATA_W-1:0] ALL_ONES        = '1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [DATA_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                m_tready  = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire [TDATA_W-1:0]   m_tdata;

    int   mismatches;
    int   outstanding;
    logic calm          = 1'b0;
    int   quiet_cycles  = 0;
    int   results_seen  = 0;
    int   requests_sent = 0;
    int   mask_writes   = 0;

    logic [DATA_W-1:0] mask_plan [PHASES];

    capability_handle_table_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    capability_handle_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result-side back-pressure, off during the calm phase
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // Watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) results_seen <= results_seen + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tb_capability_handle_table_unit: errors");
            $finish;
        end
    end

    // One request, with an optional gap in front of it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] idx,
                                input logic [DATA_W-1:0] obj, input logic [DATA_W-1:0] rts);
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{TDATA_PAD{1'b0}}, rts, obj, idx, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // Hold off until every outstanding request has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_dup_mask(input logic [DATA_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mask_writes++;
    endtask

    // Words biased toward zero, all ones, single bits and small values
    function automatic logic [DATA_W-1:0] rand_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) return '0;
        if (p < 18) return ALL_ONES;
        if (p < 48) return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
        if (p < 68) return DATA_W'($urandom_range(1, 15));
        return $urandom;
    endfunction

    // Grow phases favor alloc/duplicate/restore, shrink phases favor get/take/close
    task automatic send_random(input logic grow);
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] idx;
        int                  p;
        int                  q;
        p = $urandom_range(0, 99);
        if (p < 2) cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        else if (grow) begin
            if (p < 32) cmd = CMD_ALLOC;
            else if (p < 52) cmd = CMD_DUP;
            else if (p < 67) cmd = CMD_RESTORE;
            else if (p < 82) cmd = CMD_GET;
            else if (p < 92) cmd = CMD_TAKE;
            else cmd = CMD_CLOSE;
        end else begin
            if (p < 12) cmd = CMD_ALLOC;
            else if (p < 20) cmd = CMD_DUP;
            else if (p < 27) cmd = CMD_RESTORE;
            else if (p < 52) cmd = CMD_GET;
            else if (p < 77) cmd = CMD_TAKE;
            else cmd = CMD_CLOSE;
        end
        q = $urandom_range(0, 99);
        if (q < 80) idx = HANDLE_W'($urandom_range(0, TABLE_ENTRIES - 1));
        else if (q < 93) idx = HANDLE_W'($urandom_range(0, 7));
        else idx = HANDLE_W'($urandom_range(TABLE_ENTRIES, (1 << HANDLE_W) - 1));
        send_request(cmd, idx, rand_word(), rand_word());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: invalid entries, range edges, rights checks, duplicate cases
        send_request(CMD_ALLOC, '0, '0, ALL_ONES);
        send_request(CMD_ALLOC, '0, 32'h1, '0);
        send_request(CMD_ALLOC, 10'd1023, ALL_ONES, ALL_ONES);
        send_request(CMD_ALLOC, '0, 32'h1234_5678, 32'h2);
        send_request(CMD_GET, 10'd0, '0, '0);
        send_request(CMD_GET, 10'd0, '0, ALL_ONES);
        send_request(CMD_GET, 10'd1, '0, 32'h3);
        send_request(CMD_GET, HANDLE_W'(TABLE_ENTRIES), '0, '0);
        send_request(CMD_GET, 10'd1023, '0, '0);
        send_request(CMD_GET, 10'd5, '0, '0);
        send_request(CMD_DUP, 10'd1, '0, '0);
        send_request(CMD_DUP, 10'd0, '0, '0);
        send_request(CMD_DUP, 10'd0, '0, 32'h8000_0000);
        send_request(CMD_RESTORE, HANDLE_W'(TABLE_ENTRIES - 1), 32'h7, 32'h3);
        send_request(CMD_DUP, HANDLE_W'(TABLE_ENTRIES - 1), '0, 32'h4);
        send_request(CMD_RESTORE, HANDLE_W'(TABLE_ENTRIES - 1), 32'h9, 32'h1);
        send_request(CMD_RESTORE, HANDLE_W'(TABLE_ENTRIES), 32'h1, 32'h1);
        send_request(CMD_RESTORE, 10'd1023, '0, 32'h1);
        send_request(CMD_TAKE, HANDLE_W'(TABLE_ENTRIES - 1), '0, ALL_ONES);
        send_request(CMD_TAKE, 10'd2, '0, 32'h1);
        send_request(CMD_TAKE, 10'd2, '0, '0);
        send_request(CMD_CLOSE, 10'd3, '0, '0);
        send_request(CMD_CLOSE, 10'd3, '0, '0);
        send_request(CMD_RSVD_LO, '0, ALL_ONES, ALL_ONES);
        send_request(CMD_RSVD_HI, 10'd1023, ALL_ONES, ALL_ONES);

        // Random phases, each under its own duplicate mask
        mask_plan[0] = ALL_ONES;
        mask_plan[1] = '0;
        mask_plan[2] = 32'h8000_0000;
        mask_plan[3] = $urandom;
        mask_plan[4] = 32'h0000_00FF;
        mask_plan[5] = '0;
        mask_plan[6] = $urandom;
        mask_plan[7] = DUP_MASK_RESET;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_dup_mask(mask_plan[ph]);
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random(ph % 2 == 0);
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d requests and %0d results across %0d dup-mask settings,",
                 requests_sent, results_seen, mask_writes + 1);
        $display("alternating fill-heavy and drain-heavy command mixes, with and without stalls.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_capability_handle_table_unit: clean");
        end else begin
            $display("tb_capability_handle_table_unit: errors");
        end
        $finish;
    end

endmodule
